### rtl/lpd_pkg.sv
// Shared constants, types and state codes for the line position PID drive block.
package lpd_pkg;

  localparam int SENSOR_COUNT = 5;
  localparam int SUM_WIDTH    = 24;

  localparam int LINE_WEIGHT = 180;
  localparam int LINE_CENTER = 360;
  localparam int DRIVE_MAX   = 255;

  localparam int SAMPLE_W   = 10;
  localparam int GAIN_W     = 8;
  localparam int THRESH_W   = 10;
  localparam int DUTY_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd3;

  localparam logic [GAIN_W-1:0]   GAIN_P_RESET    = 8'd2;
  localparam logic [GAIN_W-1:0]   GAIN_I_RESET    = 8'd0;
  localparam logic [GAIN_W-1:0]   GAIN_D_RESET    = 8'd1;
  localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 10'd500;

  localparam int LANE_IDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int POS_W      = $clog2(LINE_WEIGHT * (SENSOR_COUNT - 1) + 1);
  localparam int WSUM_W     = $clog2(LINE_WEIGHT * SENSOR_COUNT * (SENSOR_COUNT - 1) / 2 + 1);
  localparam int CNT_W      = $clog2(SENSOR_COUNT + 1);
  localparam int STEP_W     = $clog2(WSUM_W + 1);
  localparam int POS_VAL_W  = (POS_W > 9) ? POS_W : 9;
  localparam int ERR_W      = POS_VAL_W + 1;
  localparam int DER_W      = ERR_W + 1;
  localparam int PP_W       = ERR_W + GAIN_W + 1;
  localparam int PI_W       = SUM_WIDTH + GAIN_W + 1;
  localparam int PD_W       = DER_W + GAIN_W + 1;
  localparam int DRIVE_W    = SUM_WIDTH + GAIN_W + 3;

  localparam logic signed [SUM_WIDTH:0] SUM_MAX =
    (SUM_WIDTH + 1)'((64'sd1 <<< (SUM_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SUM_WIDTH:0] SUM_MIN =
    (SUM_WIDTH + 1)'(-(64'sd1 <<< (SUM_WIDTH - 1)));

  typedef struct packed {
    logic [WSUM_W-1:0] weighted;
    logic [CNT_W-1:0]  count;
  } lpd_merge_t;

  typedef struct packed {
    logic              busy;
    logic [WSUM_W-1:0] quotient;
  } lpd_div_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_ERR,
    ST_MUL,
    ST_DRIVE
  } lpd_state_t;

endpackage

### rtl/line_position_pid_drive_top.sv
// Top level of the line position PID drive block: lanes, merge, divider and PID sequencer.
//
// The input channel (in_valid/in_ready) carries five raw sensor samples per item.
// The output channel (out_valid/out_ready) carries four motor duties and the held flag.
// Gains and the line threshold are written through cfg_write/cfg_index/cfg_data; the
// user must write them only while the block is idle, as the block does not enforce it;
// a write takes effect at the next clock edge. An item is taken only when the sequencer
// is idle, and the lanes are merged into a register at the accepting edge. After
// acceptance the sequencer starts the divider, waits while the bit-serial divider forms
// one quotient bit for each bit of the 11-bit weighted sum, then steps through error,
// multiply and drive before the result is loaded. The next item can be taken in the
// cycle after the result is loaded, not before.
// The result sits in an output register; a new item may be accepted while it waits.
// If the receiver stalls, the next result waits in the drive step until the previous
// one is taken, and the input channel then stays closed.
// Reset clears the integral, the previous error and the duties, restores the register
// defaults and drops out_valid.
module line_position_pid_drive_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [lpd_pkg::SAMPLE_W-1:0]     sample_0,
  input  logic [lpd_pkg::SAMPLE_W-1:0]     sample_1,
  input  logic [lpd_pkg::SAMPLE_W-1:0]     sample_2,
  input  logic [lpd_pkg::SAMPLE_W-1:0]     sample_3,
  input  logic [lpd_pkg::SAMPLE_W-1:0]     sample_4,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [lpd_pkg::DUTY_W-1:0]       right_fwd,
  output logic [lpd_pkg::DUTY_W-1:0]       right_rev,
  output logic [lpd_pkg::DUTY_W-1:0]       left_fwd,
  output logic [lpd_pkg::DUTY_W-1:0]       left_rev,
  output logic                             held,
  input  logic                             cfg_write,
  input  logic [lpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lpd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lpd_pkg::*;

  lpd_state_t state, state_next;

  logic [GAIN_W-1:0]   gain_p;
  logic [GAIN_W-1:0]   gain_i;
  logic [GAIN_W-1:0]   gain_d;
  logic [THRESH_W-1:0] line_threshold;

  logic [SAMPLE_W-1:0]     sample [SENSOR_COUNT];
  logic [SENSOR_COUNT-1:0] lane_on;
  logic [POS_W-1:0]        lane_weight [SENSOR_COUNT];

  lpd_merge_t    merged;
  lpd_div_stat_t div_stat;

  logic in_fire;
  logic div_start;
  logic out_load;
  logic all_on;

  logic signed [SUM_WIDTH-1:0] error_sum;
  logic signed [ERR_W-1:0]     previous_error;
  logic signed [ERR_W-1:0]     err_q;
  logic signed [DER_W-1:0]     deriv_q;
  logic signed [PP_W-1:0]      prod_p;
  logic signed [PI_W-1:0]      prod_i;
  logic signed [PD_W-1:0]      prod_d;

  logic signed [ERR_W-1:0]     err_now;
  logic signed [SUM_WIDTH:0]   sum_wide;
  logic signed [SUM_WIDTH-1:0] sum_next;
  logic signed [DER_W-1:0]     deriv_next;
  logic signed [DRIVE_W-1:0]   drive_sum;
  logic signed [DUTY_W:0]      drive;
  logic signed [DUTY_W:0]      duty_low;
  logic signed [DUTY_W:0]      duty_neg;

  assign sample[0] = sample_0;
  assign sample[1] = sample_1;
  assign sample[2] = sample_2;
  assign sample[3] = sample_3;
  assign sample[4] = sample_4;

  for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_lane
    lpd_lane u_lane (
      .sample    (sample[g]),
      .threshold (line_threshold),
      .index     (LANE_IDX_W'(g)),
      .on        (lane_on[g]),
      .weight    (lane_weight[g])
    );
  end

  lpd_merge u_merge (
    .clk    (clk),
    .load   (in_fire),
    .on     (lane_on),
    .weight (lane_weight),
    .merged (merged)
  );

  lpd_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .operand (merged),
    .stat    (div_stat)
  );

  assign in_fire = in_valid & in_ready;
  assign all_on  = (merged.count == CNT_W'(SENSOR_COUNT));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (!div_stat.busy) begin
          state_next = ST_ERR;
        end
      end
      ST_ERR: begin
        state_next = ST_MUL;
      end
      ST_MUL: begin
        state_next = ST_DRIVE;
      end
      ST_DRIVE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p         <= GAIN_P_RESET;
      gain_i         <= GAIN_I_RESET;
      gain_d         <= GAIN_D_RESET;
      line_threshold <= THRESHOLD_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GAIN_P:    gain_p         <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I:    gain_i         <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D:    gain_d         <= cfg_data[GAIN_W-1:0];
        REG_THRESHOLD: line_threshold <= cfg_data[THRESH_W-1:0];
      endcase
    end
  end

  always_comb begin
    err_now    = (merged.count == '0) ? '0 :
                 $signed({{(ERR_W - POS_W){1'b0}}, div_stat.quotient[POS_W-1:0]})
                 - ERR_W'(LINE_CENTER);
    sum_wide   = (SUM_WIDTH + 1)'(error_sum) + (SUM_WIDTH + 1)'(err_now);
    if (sum_wide > SUM_MAX) begin
      sum_next = SUM_MAX[SUM_WIDTH-1:0];
    end else if (sum_wide < SUM_MIN) begin
      sum_next = SUM_MIN[SUM_WIDTH-1:0];
    end else begin
      sum_next = sum_wide[SUM_WIDTH-1:0];
    end
    deriv_next = DER_W'(err_now) - DER_W'(previous_error);
  end

  always_comb begin
    drive_sum = DRIVE_W'(prod_p) - DRIVE_W'(prod_i) + DRIVE_W'(prod_d);
    if (drive_sum > DRIVE_W'(DRIVE_MAX)) begin
      drive = (DUTY_W + 1)'(DRIVE_MAX);
    end else if (drive_sum < -DRIVE_W'(DRIVE_MAX)) begin
      drive = -(DUTY_W + 1)'(DRIVE_MAX);
    end else begin
      drive = drive_sum[DUTY_W:0];
    end
    duty_low = (DUTY_W + 1)'(DRIVE_MAX) - drive;
    duty_neg = (DUTY_W + 1)'(DRIVE_MAX) + drive;
  end

  always_ff @(posedge clk) begin
    if (state == ST_ERR) begin
      err_q   <= err_now;
      deriv_q <= deriv_next;
    end
    if (state == ST_MUL) begin
      prod_p <= PP_W'(err_q * $signed({1'b0, gain_p}));
      prod_i <= PI_W'(error_sum * $signed({1'b0, gain_i}));
      prod_d <= PD_W'(deriv_q * $signed({1'b0, gain_d}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum      <= '0;
      previous_error <= '0;
      right_fwd      <= '0;
      right_rev      <= '0;
      left_fwd       <= '0;
      left_rev       <= '0;
      held           <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (state == ST_ERR) begin
        error_sum      <= sum_next;
        previous_error <= err_now;
      end
      if (out_load) begin
        out_valid <= 1'b1;
        held      <= all_on;
        if (!all_on) begin
          if (drive < 0) begin
            right_fwd <= duty_neg[DUTY_W-1:0];
            right_rev <= duty_low[DUTY_W-1:0] - DUTY_W'(DRIVE_MAX);
            left_fwd  <= DUTY_W'(DRIVE_MAX);
            left_rev  <= '0;
          end else begin
            left_fwd  <= duty_low[DUTY_W-1:0];
            left_rev  <= drive[DUTY_W-1:0];
            right_fwd <= DUTY_W'(DRIVE_MAX);
            right_rev <= '0;
          end
        end
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_div_only_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> state == ST_DIV)
    else $error("Divider busy outside the divide step.");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == ST_START)
    else $error("Accepted item did not start the sequence.");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid)
    else $error("Loaded result not presented.");

  a_duty_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && !held |->
      (right_fwd == DUTY_W'(DRIVE_MAX) && right_rev == '0) ||
      (left_fwd == DUTY_W'(DRIVE_MAX) && left_rev == '0))
    else $error("Neither motor side is at full forward duty.");

endmodule

### rtl/lpd_lane.sv
// One sensor lane: threshold compare and weighted contribution of a single sample.
module lpd_lane (
  input  logic [lpd_pkg::SAMPLE_W-1:0]   sample,
  input  logic [lpd_pkg::THRESH_W-1:0]   threshold,
  input  logic [lpd_pkg::LANE_IDX_W-1:0] index,
  output logic                           on,
  output logic [lpd_pkg::POS_W-1:0]      weight
);
  import lpd_pkg::*;

  assign on     = (sample >= threshold);
  assign weight = on ? POS_W'(int'(index) * LINE_WEIGHT) : '0;

endmodule

### rtl/lpd_merge.sv
// Merging stage: adds the lane weights and counts the lanes that are on.
module lpd_merge (
  input  logic                         clk,
  input  logic                         load,
  input  logic [lpd_pkg::SENSOR_COUNT-1:0] on,
  input  logic [lpd_pkg::POS_W-1:0]    weight [lpd_pkg::SENSOR_COUNT],
  output lpd_pkg::lpd_merge_t          merged
);
  import lpd_pkg::*;

  lpd_merge_t merged_next;

  always_comb begin
    merged_next = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      merged_next.weighted = merged_next.weighted + WSUM_W'(weight[i]);
      merged_next.count    = merged_next.count + CNT_W'(on[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      merged <= merged_next;
    end
  end

endmodule

### rtl/lpd_div.sv
// Restoring divider, one quotient bit per cycle: weighted sum over on-line count.
module lpd_div (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  lpd_pkg::lpd_merge_t    operand,
  output lpd_pkg::lpd_div_stat_t stat
);
  import lpd_pkg::*;

  logic [CNT_W-1:0]  rem;
  logic [WSUM_W-1:0] quo;
  logic [STEP_W-1:0] steps;
  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    diff;
  logic              fits;

  assign shifted = {rem, quo[WSUM_W-1]};
  assign fits    = (shifted >= {1'b0, operand.count});
  assign diff    = shifted - {1'b0, operand.count};

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= STEP_W'(WSUM_W);
    end else if (steps != '0) begin
      steps <= steps - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= operand.weighted;
    end else if (steps != '0) begin
      rem <= fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      quo <= {quo[WSUM_W-2:0], fits};
    end
  end

  assign stat.busy     = (steps != '0);
  assign stat.quotient = quo;

endmodule
